// ----- sv/cobc_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle versus oriented box collision: shared definitions
// Fixed-point constants, polynomial coefficients and pipeline payload types.
// ----------------------------------------------------------------------------
package cobc_pkg;

    localparam int unsigned CORNER_COUNT = 4;

    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [30:0] DEPTH_MAX    = 31'h7FFF_FFFF;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
    localparam logic signed [15:0] DIAG_Q14 = 16'sd11585;

    // Odd polynomial for sin(pi/2 * t), highest order first, evaluated by Horner.
    localparam int unsigned HORNER_STAGES = 5;
    localparam logic [30:0] HORNER_COEF [0:HORNER_STAGES] = '{
        31'd3864, 31'd172271, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    // Square root retires two result bits per stage, the divider two quotient bits.
    localparam int unsigned SQRT_BITS     = 32;
    localparam int unsigned SQRT_PER      = 2;
    localparam int unsigned SQRT_STAGES   = SQRT_BITS / SQRT_PER;
    localparam int unsigned DIV_BITS      = 15;
    localparam int unsigned DIV_PER       = 2;
    localparam int unsigned DIV_STAGES    = (DIV_BITS + DIV_PER - 1) / DIV_PER;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [30:0]        w;
        logic [30:0]        h;
        logic [30:0]        u_s;
        logic [30:0]        u_c;
        logic [30:0]        t_s;
        logic [30:0]        t_c;
        logic               c_one;
        logic [1:0]         quad;
    } front_t;

    typedef struct packed {
        logic               hit;
        logic               corner;
        logic               kx;
        logic               ky;
        logic signed [15:0] nx_face;
        logic signed [15:0] ny_face;
        logic [30:0]        depth;
        logic               vx_neg;
        logic               vy_neg;
        logic [30:0]        mx;
        logic [30:0]        my;
    } tail_t;

    typedef struct packed {
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [46:0] rem_x;
        logic [46:0] rem_y;
        logic [14:0] qx;
        logic [14:0] qy;
        logic [31:0] den;
    } div_t;

endpackage

// ----- sv/circle_oriented_box_collision_core.sv -----
// ----------------------------------------------------------------------------
// Circle versus oriented box collision core
// Streams circle/box pairs and returns hit flag, push normal and depth.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one circle centre and one rotated box
// (centre, half sizes, angle as a fraction of a turn) on a valid/ready channel.
// Each accepted transaction produces exactly one result transaction (hit,
// world-space normal in Q1.14 and penetration depth in unsigned Q15.16) on the output
// valid/ready channel, in order. The circle radius is held in a register that
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while the
// core is idle, which the core itself does not enforce. The radius resets to 1.0 (65536).
// The core accepts one transaction in every cycle while the output is not
// stalled. The longest section is the corner distance square root (16
// stages, two root bits each) followed by the normalising divider (8 stages,
// two quotient bits each).
// Reset clears every valid bit, so the pipeline comes up empty. When the
// receiver stalls, the whole pipeline holds: in_ready falls only while a
// result is waiting at the output and out_ready is low, and no transaction is
// lost or repeated.
// ----------------------------------------------------------------------------
module circle_oriented_box_collision_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [30:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] circle_x,
    input  logic signed [31:0] circle_y,
    input  logic signed [31:0] box_x,
    input  logic signed [31:0] box_y,
    input  logic [30:0]        half_width,
    input  logic [30:0]        half_height,
    input  logic [15:0]        box_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [30:0]        depth
);

    // Stage numbering along the pipeline.
    localparam int ST_SIN   = cobc_pkg::HORNER_STAGES + 1;
    localparam int ST_MAP   = ST_SIN + 1;
    localparam int ST_PROD  = ST_MAP + 1;
    localparam int ST_ROT   = ST_PROD + 1;
    localparam int ST_CLS   = ST_ROT + 1;
    localparam int ST_SQ    = ST_CLS + 1;
    localparam int ST_PICK  = ST_SQ + 1;
    localparam int ST_DIV0  = ST_PICK + cobc_pkg::SQRT_STAGES;
    localparam int ST_SEL   = ST_DIV0 + cobc_pkg::DIV_STAGES + 1;
    localparam int ST_WPROD = ST_SEL + 1;
    localparam int ST_OUT   = ST_WPROD + 1;
    localparam int NST      = ST_OUT + 1;

    logic            adv;
    logic [NST-1:0]  v_reg;
    logic [30:0]     radius_reg;

    // The whole pipeline moves together unless a finished result is stalled.
    assign adv       = !v_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            radius_reg <= cobc_pkg::RADIUS_RESET;
        end
        else
        begin
            if (adv)
            begin
                v_reg <= {v_reg[NST-2:0], in_valid};
            end
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: offsets and the polynomial arguments for sine and cosine.
    // The cosine of the in-quadrant angle is the sine of its complement.
    // ------------------------------------------------------------------
    cobc_pkg::front_t front_reg [0:ST_ROT];
    cobc_pkg::front_t front_in;
    logic [13:0] fs;
    logic [14:0] fc;
    logic [27:0] fs_sq;
    logic [29:0] fc_sq;

    always_comb
    begin
        fs             = box_angle[13:0];
        fc             = 15'd16384 - {1'b0, fs};
        fs_sq          = fs * fs;
        fc_sq          = fc * fc;
        front_in.dx    = {circle_x[31], circle_x} - {box_x[31], box_x};
        front_in.dy    = {circle_y[31], circle_y} - {box_y[31], box_y};
        front_in.w     = half_width;
        front_in.h     = half_height;
        front_in.u_s   = {1'b0, fs_sq, 2'b00};
        front_in.u_c   = {fc_sq[28:0], 2'b00};
        front_in.t_s   = {1'b0, fs, 16'd0};
        front_in.t_c   = {fc, 16'd0};
        front_in.c_one = (fs == 14'd0);
        front_in.quad  = box_angle[15:14];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg[0] <= front_in;
            for (int k = 1; k <= ST_ROT; k++)
            begin
                front_reg[k] <= front_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner evaluation, one coefficient per stage, sine and cosine side by side.
    // ------------------------------------------------------------------
    logic [30:0] ps_reg [1:cobc_pkg::HORNER_STAGES];
    logic [30:0] pc_reg [1:cobc_pkg::HORNER_STAGES];

    for (genvar j = 1; j <= cobc_pkg::HORNER_STAGES; j++)
    begin : g_horner
        logic [30:0] pin_s;
        logic [30:0] pin_c;
        logic [61:0] prod_s;
        logic [61:0] prod_c;

        if (j == 1)
        begin : g_first
            assign pin_s = cobc_pkg::HORNER_COEF[0];
            assign pin_c = cobc_pkg::HORNER_COEF[0];
        end
        else
        begin : g_rest
            assign pin_s = ps_reg[j-1];
            assign pin_c = pc_reg[j-1];
        end

        assign prod_s = pin_s * front_reg[j-1].u_s;
        assign prod_c = pin_c * front_reg[j-1].u_c;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ps_reg[j] <= cobc_pkg::HORNER_COEF[j] - prod_s[60:30];
                pc_reg[j] <= cobc_pkg::HORNER_COEF[j] - prod_c[60:30];
            end
        end
    end

    // Final multiply by t and clamp to one.
    logic [30:0] sin0_reg;
    logic [30:0] cos0_reg;
    logic [61:0] s_prod;
    logic [61:0] c_prod;

    assign s_prod = ps_reg[cobc_pkg::HORNER_STAGES] * front_reg[ST_SIN-1].t_s;
    assign c_prod = pc_reg[cobc_pkg::HORNER_STAGES] * front_reg[ST_SIN-1].t_c;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sin0_reg <= (s_prod[61:30] > {1'b0, cobc_pkg::ONE_Q30}) ?
                        cobc_pkg::ONE_Q30 : s_prod[60:30];
            if (front_reg[ST_SIN-1].c_one ||
                (c_prod[61:30] > {1'b0, cobc_pkg::ONE_Q30}))
            begin
                cos0_reg <= cobc_pkg::ONE_Q30;
            end
            else
            begin
                cos0_reg <= c_prod[60:30];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quadrant mapping; sine and cosine then travel with the item to the end.
    // ------------------------------------------------------------------
    logic signed [31:0] sn_line [ST_MAP:ST_SEL];
    logic signed [31:0] cs_line [ST_MAP:ST_SEL];
    logic signed [31:0] s0_s;
    logic signed [31:0] c0_s;
    logic signed [31:0] sn_map;
    logic signed [31:0] cs_map;

    always_comb
    begin
        s0_s = $signed({1'b0, sin0_reg});
        c0_s = $signed({1'b0, cos0_reg});
        case (front_reg[ST_MAP-1].quad)
            2'd0:
            begin
                sn_map = s0_s;
                cs_map = c0_s;
            end
            2'd1:
            begin
                sn_map = c0_s;
                cs_map = -s0_s;
            end
            2'd2:
            begin
                sn_map = -s0_s;
                cs_map = -c0_s;
            end
            default:
            begin
                sn_map = -c0_s;
                cs_map = s0_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn_line[ST_MAP] <= sn_map;
            cs_line[ST_MAP] <= cs_map;
            for (int k = ST_MAP + 1; k <= ST_SEL; k++)
            begin
                sn_line[k] <= sn_line[k-1];
                cs_line[k] <= cs_line[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotate the offset into box space: products, then rounded sums.
    // ------------------------------------------------------------------
    logic signed [64:0] pxc_reg;
    logic signed [64:0] pys_reg;
    logic signed [64:0] pyc_reg;
    logic signed [64:0] pxs_reg;
    logic signed [65:0] sum_rx;
    logic signed [65:0] sum_ry;
    logic signed [35:0] rx_reg;
    logic signed [35:0] ry_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxc_reg <= front_reg[ST_PROD-1].dx * cs_line[ST_PROD-1];
            pys_reg <= front_reg[ST_PROD-1].dy * sn_line[ST_PROD-1];
            pyc_reg <= front_reg[ST_PROD-1].dy * cs_line[ST_PROD-1];
            pxs_reg <= front_reg[ST_PROD-1].dx * sn_line[ST_PROD-1];
        end
    end

    assign sum_rx = 66'(pxc_reg) + 66'(pys_reg) + 66'sd536870912;
    assign sum_ry = 66'(pyc_reg) - 66'(pxs_reg) + 66'sd536870912;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg <= sum_rx[65:30];
            ry_reg <= sum_ry[65:30];
        end
    end

    // ------------------------------------------------------------------
    // Classification: bounding test, face tests, face depths, corner offsets.
    // ------------------------------------------------------------------
    logic [35:0]        arx;
    logic [35:0]        ary;
    logic [31:0]        wr;
    logic [31:0]        hr;
    logic signed [36:0] rx37;
    logic signed [36:0] ry37;
    logic signed [36:0] ws;
    logic signed [36:0] hs;
    logic signed [36:0] rs;

    logic               pass_reg;
    logic               face_y_reg;
    logic               face_x_reg;
    logic               rx_neg_reg;
    logic               ry_neg_reg;
    logic signed [36:0] dfx_reg;
    logic signed [36:0] dfy_reg;
    logic signed [36:0] vx_reg [0:1];
    logic signed [36:0] vy_reg [0:1];

    always_comb
    begin
        arx  = rx_reg[35] ? 36'(-rx_reg) : 36'(rx_reg);
        ary  = ry_reg[35] ? 36'(-ry_reg) : 36'(ry_reg);
        wr   = {1'b0, front_reg[ST_CLS-1].w} + {1'b0, radius_reg};
        hr   = {1'b0, front_reg[ST_CLS-1].h} + {1'b0, radius_reg};
        rx37 = 37'(rx_reg);
        ry37 = 37'(ry_reg);
        ws   = $signed({6'd0, front_reg[ST_CLS-1].w});
        hs   = $signed({6'd0, front_reg[ST_CLS-1].h});
        rs   = $signed({6'd0, radius_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass_reg   <= (arx <= {4'd0, wr}) && (ary <= {4'd0, hr});
            face_y_reg <= (rx37 > -ws) && (rx37 < ws);
            face_x_reg <= (ry37 > -hs) && (ry37 < hs);
            rx_neg_reg <= rx_reg[35];
            ry_neg_reg <= ry_reg[35];
            dfy_reg    <= ry_reg[35] ? (ry37 + rs + hs) : (hs + rs - ry37);
            dfx_reg    <= rx_reg[35] ? (rx37 + rs + ws) : (ws + rs - rx37);
            vx_reg[0]  <= rx37 + ws;
            vx_reg[1]  <= rx37 - ws;
            vy_reg[0]  <= ry37 + hs;
            vy_reg[1]  <= ry37 - hs;
        end
    end

    // ------------------------------------------------------------------
    // Corner squares: two x offsets and two y offsets cover the four corners.
    // ------------------------------------------------------------------
    logic               pass_q;
    logic               face_y_q;
    logic               face_x_q;
    logic               ry_neg_q;
    logic               rx_neg_q;
    logic signed [36:0] dfx_q;
    logic signed [36:0] dfy_q;
    logic [1:0]         okx_q;
    logic [1:0]         oky_q;
    logic [1:0]         vxn_q;
    logic [1:0]         vyn_q;
    logic [30:0]        mx_q [0:1];
    logic [30:0]        my_q [0:1];
    logic [61:0]        sqx_q [0:1];
    logic [61:0]        sqy_q [0:1];
    logic [61:0]        rr_q;

    for (genvar i = 0; i < 2; i++)
    begin : g_sq
        logic [36:0] avx;
        logic [36:0] avy;

        assign avx = vx_reg[i][36] ? 37'(-vx_reg[i]) : 37'(vx_reg[i]);
        assign avy = vy_reg[i][36] ? 37'(-vy_reg[i]) : 37'(vy_reg[i]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                okx_q[i] <= avx < {6'd0, radius_reg};
                oky_q[i] <= avy < {6'd0, radius_reg};
                vxn_q[i] <= vx_reg[i][36];
                vyn_q[i] <= vy_reg[i][36];
                mx_q[i]  <= avx[30:0];
                my_q[i]  <= avy[30:0];
                sqx_q[i] <= avx[30:0] * avx[30:0];
                sqy_q[i] <= avy[30:0] * avy[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass_q   <= pass_reg;
            face_y_q <= face_y_reg;
            face_x_q <= face_x_reg;
            ry_neg_q <= ry_neg_reg;
            rx_neg_q <= rx_neg_reg;
            dfx_q    <= dfx_reg;
            dfy_q    <= dfy_reg;
            rr_q     <= radius_reg * radius_reg;
        end
    end

    // ------------------------------------------------------------------
    // Choice of face or first qualifying corner.
    // ------------------------------------------------------------------
    cobc_pkg::tail_t tail_reg [ST_PICK:ST_SEL-1];
    cobc_pkg::sqrt_t sq_reg [0:cobc_pkg::SQRT_STAGES];
    cobc_pkg::tail_t tail_pick;
    logic [62:0] n2 [0:cobc_pkg::CORNER_COUNT-1];
    logic [cobc_pkg::CORNER_COUNT-1:0] qual;
    logic        found;
    logic [1:0]  ksel;
    logic signed [36:0] dmax;

    always_comb
    begin
        dmax  = $signed({6'd0, cobc_pkg::DEPTH_MAX});
        found = 1'b0;
        ksel  = 2'd0;
        for (int k = 0; k < cobc_pkg::CORNER_COUNT; k++)
        begin
            n2[k]   = {1'b0, sqx_q[k % 2]} + {1'b0, sqy_q[k / 2]};
            qual[k] = okx_q[k % 2] && oky_q[k / 2] && (n2[k] < {1'b0, rr_q});
            if (!found && qual[k])
            begin
                found = 1'b1;
                ksel  = 2'(k);
            end
        end

        tail_pick.hit     = 1'b0;
        tail_pick.corner  = 1'b0;
        tail_pick.kx      = ksel[0];
        tail_pick.ky      = ksel[1];
        tail_pick.nx_face = '0;
        tail_pick.ny_face = '0;
        tail_pick.depth   = '0;
        tail_pick.vx_neg  = vxn_q[ksel[0]];
        tail_pick.vy_neg  = vyn_q[ksel[1]];
        tail_pick.mx      = mx_q[ksel[0]];
        tail_pick.my      = my_q[ksel[1]];

        if (pass_q)
        begin
            if (face_y_q)
            begin
                tail_pick.hit     = dfy_q > 37'sd0;
                tail_pick.ny_face = ry_neg_q ? -cobc_pkg::UNIT_Q14 : cobc_pkg::UNIT_Q14;
                tail_pick.depth   = (dfy_q > dmax) ? cobc_pkg::DEPTH_MAX : dfy_q[30:0];
            end
            else if (face_x_q)
            begin
                tail_pick.hit     = dfx_q > 37'sd0;
                tail_pick.nx_face = rx_neg_q ? -cobc_pkg::UNIT_Q14 : cobc_pkg::UNIT_Q14;
                tail_pick.depth   = (dfx_q > dmax) ? cobc_pkg::DEPTH_MAX : dfx_q[30:0];
            end
            else
            begin
                tail_pick.hit    = found;
                tail_pick.corner = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg[ST_PICK] <= tail_pick;
            sq_reg[0].x       <= {1'b0, n2[ksel]};
            sq_reg[0].rem     <= '0;
            sq_reg[0].root    <= '0;
            for (int k = ST_PICK + 1; k <= ST_SEL - 1; k++)
            begin
                tail_reg[k] <= tail_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Digit-by-digit square root of the squared corner distance.
    // ------------------------------------------------------------------
    function automatic cobc_pkg::sqrt_t sqrt_steps(input cobc_pkg::sqrt_t a);
        cobc_pkg::sqrt_t b;
        logic [35:0]     acc;
        logic [35:0]     trial;
        b = a;
        for (int i = 0; i < cobc_pkg::SQRT_PER; i++)
        begin
            acc   = {b.rem, b.x[63:62]};
            trial = {2'b00, b.root, 2'b01};
            b.x   = {b.x[61:0], 2'b00};
            if (acc >= trial)
            begin
                acc    = acc - trial;
                b.root = {b.root[30:0], 1'b1};
            end
            else
            begin
                b.root = {b.root[30:0], 1'b0};
            end
            b.rem = acc[33:0];
        end
        return b;
    endfunction

    for (genvar s = 1; s <= cobc_pkg::SQRT_STAGES; s++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[s] <= sqrt_steps(sq_reg[s-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring division for the normal components, rounded half up.
    // ------------------------------------------------------------------
    function automatic cobc_pkg::div_t div_steps(input cobc_pkg::div_t a, input int top);
        cobc_pkg::div_t b;
        logic [46:0]    sh;
        int             bit_i;
        b = a;
        for (int j = 0; j < cobc_pkg::DIV_PER; j++)
        begin
            bit_i = top - j;
            if (bit_i >= 0)
            begin
                sh = 47'(b.den) << bit_i;
                if (b.rem_x >= sh)
                begin
                    b.rem_x = b.rem_x - sh;
                    b.qx    = b.qx | (15'd1 << bit_i);
                end
                if (b.rem_y >= sh)
                begin
                    b.rem_y = b.rem_y - sh;
                    b.qy    = b.qy | (15'd1 << bit_i);
                end
            end
        end
        return b;
    endfunction

    cobc_pkg::div_t dv_reg [1:cobc_pkg::DIV_STAGES];
    cobc_pkg::div_t dv_setup;
    logic [31:0]    len_sq;

    always_comb
    begin
        len_sq         = sq_reg[cobc_pkg::SQRT_STAGES].root;
        dv_setup.den   = len_sq;
        dv_setup.rem_x = 47'({tail_reg[ST_DIV0].mx, 14'd0}) + 47'(len_sq[31:1]);
        dv_setup.rem_y = 47'({tail_reg[ST_DIV0].my, 14'd0}) + 47'(len_sq[31:1]);
        dv_setup.qx    = '0;
        dv_setup.qy    = '0;
    end

    for (genvar d = 1; d <= cobc_pkg::DIV_STAGES; d++)
    begin : g_div
        localparam int TOP = cobc_pkg::DIV_BITS - 1 - (d - 1) * cobc_pkg::DIV_PER;

        if (d == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[d] <= div_steps(dv_setup, TOP);
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[d] <= div_steps(dv_reg[d-1], TOP);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Box-space normal and depth, then rotation back to world space.
    // ------------------------------------------------------------------
    cobc_pkg::tail_t    tl;
    cobc_pkg::div_t     dl;
    logic signed [15:0] qx_s;
    logic signed [15:0] qy_s;
    logic signed [15:0] nx_sel;
    logic signed [15:0] ny_sel;
    logic [30:0]        depth_sel;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic [30:0]        depth_s_reg;
    logic               hit_s_reg;

    always_comb
    begin
        tl        = tail_reg[ST_SEL-1];
        dl        = dv_reg[cobc_pkg::DIV_STAGES];
        qx_s      = $signed({1'b0, dl.qx});
        qy_s      = $signed({1'b0, dl.qy});
        nx_sel    = '0;
        ny_sel    = '0;
        depth_sel = '0;
        if (tl.hit)
        begin
            if (tl.corner)
            begin
                depth_sel = radius_reg - dl.den[30:0];
                if (dl.den == 32'd0)
                begin
                    // Centre exactly on the corner: push out along the diagonal.
                    nx_sel = tl.kx ? cobc_pkg::DIAG_Q14 : -cobc_pkg::DIAG_Q14;
                    ny_sel = tl.ky ? cobc_pkg::DIAG_Q14 : -cobc_pkg::DIAG_Q14;
                end
                else
                begin
                    nx_sel = tl.vx_neg ? -qx_s : qx_s;
                    ny_sel = tl.vy_neg ? -qy_s : qy_s;
                end
            end
            else
            begin
                nx_sel    = tl.nx_face;
                ny_sel    = tl.ny_face;
                depth_sel = tl.depth;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg      <= nx_sel;
            ny_reg      <= ny_sel;
            depth_s_reg <= depth_sel;
            hit_s_reg   <= tl.hit;
        end
    end

    logic signed [47:0] wxc_reg;
    logic signed [47:0] wys_reg;
    logic signed [47:0] wxs_reg;
    logic signed [47:0] wyc_reg;
    logic [30:0]        depth_w_reg;
    logic               hit_w_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wxc_reg     <= nx_reg * cs_line[ST_SEL];
            wys_reg     <= ny_reg * sn_line[ST_SEL];
            wxs_reg     <= nx_reg * sn_line[ST_SEL];
            wyc_reg     <= ny_reg * cs_line[ST_SEL];
            depth_w_reg <= depth_s_reg;
            hit_w_reg   <= hit_s_reg;
        end
    end

    logic signed [48:0] sum_wx;
    logic signed [48:0] sum_wy;
    logic signed [18:0] wx_r;
    logic signed [18:0] wy_r;
    logic signed [15:0] wx_c;
    logic signed [15:0] wy_c;
    logic signed [18:0] unit19;

    always_comb
    begin
        unit19 = 19'(cobc_pkg::UNIT_Q14);
        sum_wx = 49'(wxc_reg) - 49'(wys_reg) + 49'sd536870912;
        sum_wy = 49'(wxs_reg) + 49'(wyc_reg) + 49'sd536870912;
        wx_r   = sum_wx[48:30];
        wy_r   = sum_wy[48:30];
        if (wx_r > unit19)
        begin
            wx_c = cobc_pkg::UNIT_Q14;
        end
        else if (wx_r < -unit19)
        begin
            wx_c = -cobc_pkg::UNIT_Q14;
        end
        else
        begin
            wx_c = wx_r[15:0];
        end
        if (wy_r > unit19)
        begin
            wy_c = cobc_pkg::UNIT_Q14;
        end
        else if (wy_r < -unit19)
        begin
            wy_c = -cobc_pkg::UNIT_Q14;
        end
        else
        begin
            wy_c = wy_r[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit      <= hit_w_reg;
            normal_x <= wx_c;
            normal_y <= wy_c;
            depth    <= depth_w_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> normal_x == 16'sd0 && normal_y == 16'sd0 && depth == 31'd0)
        else $error("miss result carries a non-zero normal or depth");

    a_hit_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> depth != 31'd0)
        else $error("hit result with zero depth");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                      normal_y <= 16'sd16384 && normal_y >= -16'sd16384)
        else $error("normal component out of range");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output is stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted transaction did not enter the pipeline");

endmodule

// ----- verif/tb_circle_oriented_box_collision_core.sv -----
// ----------------------------------------------------------------------------
// Circle versus oriented box collision core: self-checking testbench
// Streams directed and random circle/box pairs through the core under random
// idling on both channels, predicts each collision result in the bench and
// compares every returned transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_circle_oriented_box_collision_core;

    timeunit 1ns;
    timeprecision 1ps;

    // One pending pair as the driver presents it.
    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        hw;
        logic [30:0]        hh;
        logic [15:0]        ang;
    } pair_t;

    // One collision outcome.
    typedef struct {
        logic               hit;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        depth;
    } contact_t;

    localparam int LATENCY = 40;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [30:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] circle_x;
    logic signed [31:0] circle_y;
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic [30:0]        half_width;
    logic [30:0]        half_height;
    logic [15:0]        box_angle;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [30:0]        depth;

    pair_t    pending_pairs[$];
    contact_t expected_contacts[$];
    logic [30:0] bench_radius;
    int          error_count;
    bit          hold_sender;
    int          send_gap;
    int          recv_gap;

    circle_oriented_box_collision_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .circle_x    (circle_x),
        .circle_y    (circle_y),
        .box_x       (box_x),
        .box_y       (box_y),
        .half_width  (half_width),
        .half_height (half_height),
        .box_angle   (box_angle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .depth       (depth)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Gap lengths: mostly zero or short, occasionally long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Arithmetic right shift rounding towards minus infinity.
    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd30(longint v);
        return shr_floor(v + (longint'(1) << 29), 30);
    endfunction

    // sin(pi/2 * t) in Q30 from the odd Horner polynomial.
    function automatic longint quarter_sin(longint t);
        longint unsigned u;
        longint unsigned p;
        longint unsigned s;
        if (t >= 64'sd1073741824)
            return 64'sd1073741824;
        u = (longint'(t) * t) >> 30;
        p = 3864;
        p = 64'd172271 - ((p * u) >> 30);
        p = 64'd5026995 - ((p * u) >> 30);
        p = 64'd85569306 - ((p * u) >> 30);
        p = 64'd693598668 - ((p * u) >> 30);
        p = 64'd1686629713 - ((p * u) >> 30);
        s = (p * longint'(t)) >> 30;
        if (s > 64'd1073741824)
            s = 64'd1073741824;
        return longint'(s);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_component(longint v, longint len);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q = (mag * 16384 + len / 2) / len;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint clamp_q14(longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    // Predicts the collision outcome of one pair at the current radius.
    function automatic contact_t collide(pair_t p, logic [30:0] rad);
        contact_t c;
        longint dx, dy, w, h, r, sn, cs, s0, c0, f, rx, ry, arx, ary, d;
        longint nx, ny, dep, vx, vy, avx, avy;
        longint unsigned n2, len;
        logic [1:0] quad;
        bit found;
        dx = longint'(p.cx) - longint'(p.bx);
        dy = longint'(p.cy) - longint'(p.by);
        w = longint'({1'b0, p.hw});
        h = longint'({1'b0, p.hh});
        r = longint'({1'b0, rad});
        quad = p.ang[15:14];
        f = longint'(p.ang[13:0]) << 16;
        s0 = quarter_sin(f);
        c0 = quarter_sin(64'sd1073741824 - f);
        case (quad)
            2'd0: begin sn = s0;  cs = c0;  end
            2'd1: begin sn = c0;  cs = -s0; end
            2'd2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
        rx = rnd30(dx * cs + dy * sn);
        ry = rnd30(dy * cs - dx * sn);
        arx = (rx < 0) ? -rx : rx;
        ary = (ry < 0) ? -ry : ry;
        nx = 0;
        ny = 0;
        dep = 0;
        found = 0;
        if (arx <= w + r && ary <= h + r)
        begin
            if (rx > -w && rx < w)
            begin
                d = (ry < 0) ? ry + r + h : h - ry + r;
                if (d > 0)
                begin
                    ny = (ry < 0) ? -16384 : 16384;
                    dep = d;
                    found = 1;
                end
            end
            else if (ry > -h && ry < h)
            begin
                d = (rx < 0) ? rx + r + w : w - rx + r;
                if (d > 0)
                begin
                    nx = (rx < 0) ? -16384 : 16384;
                    dep = d;
                    found = 1;
                end
            end
            else
            begin
                // Corners in order: (-w,-h), (+w,-h), (-w,+h), (+w,+h).
                for (int k = 0; k < cobc_pkg::CORNER_COUNT && !found; k++)
                begin
                    vx = rx - ((k & 1) ? w : -w);
                    vy = ry - ((k & 2) ? h : -h);
                    avx = (vx < 0) ? -vx : vx;
                    avy = (vy < 0) ? -vy : vy;
                    if (avx < r && avy < r)
                    begin
                        n2 = longint'(avx) * avx + longint'(avy) * avy;
                        if (n2 < longint'(r) * r)
                        begin
                            len = floor_sqrt(n2);
                            dep = r - longint'(len);
                            if (len == 0)
                            begin
                                // Centre exactly on the corner: outward diagonal.
                                nx = (k & 1) ? 11585 : -11585;
                                ny = (k & 2) ? 11585 : -11585;
                            end
                            else
                            begin
                                nx = unit_component(vx, longint'(len));
                                ny = unit_component(vy, longint'(len));
                            end
                            found = 1;
                        end
                    end
                end
            end
        end
        c.hit = found;
        if (found)
        begin
            c.nx = 16'(clamp_q14(rnd30(nx * cs - ny * sn)));
            c.ny = 16'(clamp_q14(rnd30(nx * sn + ny * cs)));
            c.depth = (dep > 64'sh7FFFFFFF) ? 31'h7FFF_FFFF : 31'(dep);
        end
        else
        begin
            c.nx = '0;
            c.ny = '0;
            c.depth = '0;
        end
        return c;
    endfunction

    // Driver: presents queued pairs, holding each until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_contacts.push_back(collide('{circle_x, circle_y, box_x, box_y,
                    half_width, half_height, box_angle}, bench_radius));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!hold_sender && pending_pairs.size() > 0)
                begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    circle_x    <= p.cx;
                    circle_y    <= p.cy;
                    box_x       <= p.bx;
                    box_y       <= p.by;
                    half_width  <= p.hw;
                    half_height <= p.hh;
                    box_angle   <= p.ang;
                    in_valid    <= 1'b1;
                    send_gap    <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each returned transaction and stalls the receiver at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_contacts.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b nx=%0d ny=%0d depth=%0d",
                             $realtime, hit, normal_x, normal_y, depth);
                    error_count++;
                end
                else
                begin
                    contact_t e;
                    e = expected_contacts.pop_front();
                    if (hit !== e.hit || normal_x !== e.nx || normal_y !== e.ny
                        || depth !== e.depth)
                    begin
                        $display("%0t: mismatch expected hit=%0b nx=%0d ny=%0d depth=%0d",
                                 $realtime, e.hit, e.nx, e.ny, e.depth);
                        $display("%0t:            actual hit=%0b nx=%0d ny=%0d depth=%0d",
                                 $realtime, hit, normal_x, normal_y, depth);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  <= pick_gap();
            end
        end
    end

    function automatic pair_t make_pair(longint cx, longint cy, longint bx, longint by,
                                        longint hw, longint hh, longint ang);
        pair_t p;
        p.cx = 32'(cx);
        p.cy = 32'(cy);
        p.bx = 32'(bx);
        p.by = 32'(by);
        p.hw = 31'(hw);
        p.hh = 31'(hh);
        p.ang = 16'(ang);
        return p;
    endfunction

    // Random pair: mostly near contact at modest scales, some full-range noise.
    function automatic pair_t random_pair(logic [30:0] rad);
        pair_t p;
        int mode;
        longint span;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            p.cx = $urandom;
            p.cy = $urandom;
            p.bx = $urandom;
            p.by = $urandom;
            p.hw = 31'($urandom);
            p.hh = 31'($urandom);
        end
        else
        begin
            p.hw = 31'($urandom_range(0, 32'h0008_0000));
            p.hh = 31'($urandom_range(0, 32'h0008_0000));
            span = longint'(p.hw) + longint'(p.hh) + longint'(rad) + 65536;
            if (span > 64'sh3FFF_FFFF)
                span = 64'sh3FFF_FFFF;
            p.bx = $urandom;
            p.by = $urandom;
            p.bx[31:30] = {p.bx[29], p.bx[29]};
            p.by[31:30] = {p.by[29], p.by[29]};
            p.cx = p.bx + 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
            p.cy = p.by + 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
            if (mode == 9)
            begin
                // Circle centre offset from the box centre by the half sizes: a box corner only when unrotated.
                p.cx = p.bx + ($urandom_range(0, 1) ? 32'(p.hw) : -32'(p.hw));
                p.cy = p.by + ($urandom_range(0, 1) ? 32'(p.hh) : -32'(p.hh));
            end
        end
        p.ang = ($urandom_range(0, 3) == 0) ? 16'(($urandom_range(0, 7)) << 13) : 16'($urandom);
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || in_valid || expected_contacts.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_radius(logic [30:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        bench_radius = value;
    endtask

    initial
    begin
        logic [30:0] radii[6];
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        circle_x     = '0;
        circle_y     = '0;
        box_x        = '0;
        box_y        = '0;
        half_width   = '0;
        half_height  = '0;
        box_angle    = '0;
        error_count  = 0;
        hold_sender  = 0;
        bench_radius = cobc_pkg::RADIUS_RESET;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs at the reset radius of 1.0.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(0, 150000, 0, 0, 131072, 65536, 0));
        pending_pairs.push_back(make_pair(0, -150000, 0, 0, 131072, 65536, 16384));
        pending_pairs.push_back(make_pair(150000, 0, 0, 0, 65536, 131072, 32768));
        pending_pairs.push_back(make_pair(-150000, 0, 0, 0, 65536, 131072, 49152));
        pending_pairs.push_back(make_pair(65536, 65536, 0, 0, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(-65536, -65536, 0, 0, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(100000, 100000, 0, 0, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(100000, -90000, 0, 0, 65536, 65536, 8192));
        pending_pairs.push_back(make_pair(900000, 0, 0, 0, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(0, 196608, 0, 0, 65536, 131072, 0));
        pending_pairs.push_back(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                          -32'sh8000_0000, -32'sh8000_0000,
                                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 65535));
        pending_pairs.push_back(make_pair(-32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0,
                                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 12345));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
        pending_pairs.push_back(make_pair(12345, -6789, 100, 200, 3000, 4000, 40000));
        wait_drained();

        // Radius sweep including zero and the largest value.
        radii = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd20000, 31'd300000, 31'd65536};
        foreach (radii[i])
        begin
            write_radius(radii[i]);
            pending_pairs.push_back(make_pair(0, 0, 0, 0, 65536, 65536, 0));
            pending_pairs.push_back(make_pair(65536, 65536, 0, 0, 65536, 65536, 0));
            pending_pairs.push_back(make_pair(0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
            for (int n = 0; n < 300; n++)
            begin
                pending_pairs.push_back(random_pair(bench_radius));
                // Part way through, hold the sender until the pipeline has emptied.
                if (n == 150 && i == 2)
                begin
                    while (pending_pairs.size() > 0 || in_valid)
                        @(posedge clk);
                    hold_sender = 1;
                    while (expected_contacts.size() > 0)
                        @(posedge clk);
                    hold_sender = 0;
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
